### rtl/wav_header_stream_parser_top_assert.svh
// Assertion macros for the WAV header parser.
`ifndef WAV_HEADER_STREAM_PARSER_TOP_ASSERT_SVH
`define WAV_HEADER_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WHP_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define WHP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define WHP_ASSERT_IMPL(label, clk, rst_n, prop)
`define WHP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/whp_pkg.sv
package whp_pkg;
	localparam int MAX_CHANNELS = 8;
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [15:0] FMT_PCM = 16'h0001;
	localparam logic [15:0] FMT_FLOAT = 16'h0003;
	localparam logic [15:0] FMT_EXT = 16'hFFFE;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CORRUPT = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;
	localparam logic [1:0] REG_BUFLEN = 2'd0;
	localparam logic [1:0] REG_MINRATE = 2'd1;
	localparam logic [1:0] REG_MAXRATE = 2'd2;
	localparam int QDEPTH = 2;

	// Outcome of one file, handed from the byte parser to the finisher.
	typedef struct packed {
		logic [1:0] status;
		logic is_float;
		logic [3:0] channels;
		logic [23:0] sample_rate;
		logic [6:0] sample_bits;
		logic [6:0] frame_bytes;
		logic [31:0] data_offset;
		logic [31:0] data_length;
	} outcome_t;

	typedef struct packed {
		logic [1:0] status;
		logic is_float;
		logic [3:0] channels;
		logic [23:0] sample_rate;
		logic [6:0] sample_bits;
		logic [6:0] frame_bytes;
		logic [31:0] data_offset;
		logic [31:0] data_length;
		logic [31:0] frame_count;
	} result_t;
endpackage

### rtl/wav_header_stream_parser_top.sv
// WAV header parser.
// Bytes of a WAV file enter through a queue-like port: a byte is taken when
// push is high and full is low; last_byte marks the final byte of a file.
// Exactly one result per file leaves through empty/pop: it is shown while
// empty is low and taken when pop is high. The APB port sets buffer_length
// (0x0), min_rate (0x4) and max_rate (0x8); write only while idle.
// The byte parser takes one byte per cycle while full is low. Each outcome
// enters a 2-entry queue, then a divider computes frame_count one quotient
// bit a cycle; it takes the next outcome only after its result is popped.
// full rises when the outcome queue holds two outcomes, or holds one while
// the parser is writing another into it.
// A stalled pop holds the result; queue back-pressure then stalls bytes.
// Reset clears the parse state, empties the queue and restores the
// registers to 0, 8000 and 192000.
module wav_header_stream_parser_top (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] file_byte,
	input logic last_byte,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic is_float,
	output logic [3:0] channels,
	output logic [23:0] sample_rate,
	output logic [6:0] sample_bits,
	output logic [6:0] frame_bytes,
	output logic [31:0] data_offset,
	output logic [31:0] data_length,
	output logic [31:0] frame_count,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import whp_pkg::*;

	logic [31:0] buf_len_q;
	logic [23:0] min_rate_q, max_rate_q;
	logic f_valid;
	outcome_t f_item;
	outcome_t q_mem [QDEPTH];
	logic q_wp_q, q_rp_q;
	logic [1:0] q_cnt_q;
	logic b_ready, b_valid;
	result_t b_item;
	logic accept;

	assign pready = 1'b1;
	// Hold off bytes when the queue cannot absorb a result already in flight.
	assign full = (q_cnt_q == 2'(QDEPTH)) || (q_cnt_q == 2'(QDEPTH - 1) && f_valid);
	assign accept = push && !full;

	always_comb begin
		unique case (paddr[3:2])
			REG_BUFLEN: prdata = buf_len_q;
			REG_MINRATE: prdata = {8'd0, min_rate_q};
			REG_MAXRATE: prdata = {8'd0, max_rate_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= '0;
			min_rate_q <= 24'd8000;
			max_rate_q <= 24'd192000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_BUFLEN: buf_len_q <= pwdata;
				REG_MINRATE: min_rate_q <= pwdata[23:0];
				REG_MAXRATE: max_rate_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	whp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept), .file_byte(file_byte),
		.last_byte(last_byte), .buffer_length(buf_len_q), .min_rate(min_rate_q),
		.max_rate(max_rate_q), .out_valid(f_valid), .out_item(f_item)
	);

	// Outcome queue between the parser and the divider.
	always_ff @(posedge clk) begin
		if (f_valid) q_mem[q_wp_q] <= f_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q <= 1'b0;
			q_rp_q <= 1'b0;
			q_cnt_q <= '0;
		end else begin
			if (f_valid) q_wp_q <= !q_wp_q;
			if (b_ready && q_cnt_q != 2'd0) q_rp_q <= !q_rp_q;
			q_cnt_q <= q_cnt_q + {1'b0, f_valid} - {1'b0, b_ready && q_cnt_q != 2'd0};
		end
	end

	whp_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_cnt_q != 2'd0), .in_item(q_mem[q_rp_q]),
		.in_ready(b_ready), .out_valid(b_valid), .out_item(b_item), .out_ready(pop)
	);

	assign empty = !b_valid;
	assign status = b_item.status;
	assign is_float = b_item.is_float;
	assign channels = b_item.channels;
	assign sample_rate = b_item.sample_rate;
	assign sample_bits = b_item.sample_bits;
	assign frame_bytes = b_item.frame_bytes;
	assign data_offset = b_item.data_offset;
	assign data_length = b_item.data_length;
	assign frame_count = b_item.frame_count;

	`include "wav_header_stream_parser_top_assert.svh"
	`WHP_ASSERT_NEVER(a_q_over, clk, arst_n, (q_cnt_q > 2'(QDEPTH)))
	`WHP_ASSERT_NEVER(a_q_push_full, clk, arst_n, (f_valid && q_cnt_q == 2'(QDEPTH)))
	`WHP_ASSERT_IMPL(a_cfg_rd, clk, arst_n, (psel && penable && pwrite && paddr[3:2] == REG_BUFLEN
		|=> buf_len_q == $past(pwdata)))
endmodule

### rtl/whp_front.sv
module whp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] file_byte,
	input logic last_byte,
	input logic [31:0] buffer_length,
	input logic [23:0] min_rate,
	input logic [23:0] max_rate,
	output logic out_valid,
	output whp_pkg::outcome_t out_item
);
	import whp_pkg::*;

	typedef enum logic [1:0] {PH_RIFF, PH_HDR, PH_FMT} phase_t;

	phase_t phase_q;
	logic [31:0] pos_q, riff_end_q, tag_q, size_q, next_q;
	logic [63:0] ff0_q, ff1_q;
	logic cf_float_q;
	logic [3:0] cf_nch_q;
	logic [23:0] cf_rate_q;
	logic [6:0] cf_bits_q, cf_fb_q;
	logic fmt_seen_q, given_q;

	// combinational step
	logic [31:0] tag_n, size_n;
	logic [63:0] ff0_n, ff1_n;
	logic [1:0] st;
	logic st_v;
	logic adv_v;
	logic [32:0] adv_nx;
	logic to_fmt;
	logic [31:0] dat_off, dat_len, size_fmt;
	logic commit;
	logic [6:0] c_fb;
	logic c_float;
	logic [31:0] k_hdr;
	logic [32:0] k_fmt, fstart, body, avail;
	logic [15:0] f_tag, f_nch, f_align, f_bits, f_valid, f_sub, etag;
	logic [31:0] f_rate;
	logic ext;
	logic [7:0] fbw;
	logic [32:0] e_riff;
	logic [32:0] sz_c;

	always_comb begin
		tag_n = tag_q;
		size_n = size_q;
		ff0_n = ff0_q;
		ff1_n = ff1_q;
		st = ST_CORRUPT;
		st_v = 1'b0;
		adv_v = 1'b0;
		adv_nx = '0;
		to_fmt = 1'b0;
		dat_off = '0;
		dat_len = '0;
		size_fmt = size_q;
		commit = 1'b0;
		c_fb = '0;
		c_float = 1'b0;
		k_hdr = pos_q - next_q;
		fstart = {1'b0, next_q} + 33'd8;
		k_fmt = {1'b0, pos_q} - fstart;
		body = fstart;
		avail = ({1'b0, riff_end_q} >= body) ? ({1'b0, riff_end_q} - body) : '0;
		e_riff = '0;
		sz_c = '0;
		f_tag = '0; f_nch = '0; f_align = '0; f_bits = '0; f_valid = '0; f_sub = '0;
		f_rate = '0; ext = 1'b0; etag = '0; fbw = '0;
		if (!given_q) begin
			unique case (phase_q)
				PH_RIFF: begin
					if (pos_q == 32'd0 && buffer_length < 32'd12) begin
						st_v = 1'b1;
					end else begin
						if (pos_q < 32'd4 || (pos_q >= 32'd8 && pos_q < 32'd12))
							tag_n = {file_byte, tag_q[31:8]};
						else if (pos_q < 32'd8)
							size_n = {file_byte, size_q[31:8]};
						if (pos_q == 32'd3 && tag_n != TAG_RIFF) st_v = 1'b1;
						if (pos_q == 32'd11) begin
							if (tag_n != TAG_WAVE) st_v = 1'b1;
							else begin
								adv_v = 1'b1;
								adv_nx = 33'd12;
							end
						end
					end
				end
				PH_HDR: begin
					if (pos_q >= next_q) begin
						if (k_hdr < 32'd4) tag_n = {file_byte, tag_q[31:8]};
						else if (k_hdr < 32'd8) size_n = {file_byte, size_q[31:8]};
						if (k_hdr == 32'd7) begin
							sz_c = {1'b0, size_n};
							if (sz_c > avail) begin
								if (tag_n != TAG_DATA) st_v = 1'b1;
								sz_c = avail;
							end
							if (!st_v) begin
								if (tag_n == TAG_FMT) begin
									if (sz_c < 33'd16) st_v = 1'b1;
									else begin
										to_fmt = 1'b1;
										size_fmt = sz_c[31:0];
									end
								end else if (tag_n == TAG_DATA) begin
									st_v = 1'b1;
									if (fmt_seen_q) begin
										st = ST_OK;
										dat_off = body[31:0];
										dat_len = sz_c[31:0];
									end
								end else begin
									adv_v = 1'b1;
									adv_nx = body + sz_c + {32'd0, sz_c[0]};
								end
							end
						end
					end
				end
				PH_FMT: begin
					if (k_fmt[32] == 1'b0) begin
						if (k_fmt < 33'd8)
							ff0_n[k_fmt[2:0]*8 +: 8] = file_byte;
						else if (k_fmt >= 33'd12 && k_fmt < 33'd16)
							ff1_n[k_fmt[1:0]*8 +: 8] = file_byte;
						else if (k_fmt == 33'd18) ff1_n[39:32] = file_byte;
						else if (k_fmt == 33'd19) ff1_n[47:40] = file_byte;
						else if (k_fmt == 33'd24) ff1_n[55:48] = file_byte;
						else if (k_fmt == 33'd25) ff1_n[63:56] = file_byte;
						f_tag = ff0_n[15:0];
						f_nch = ff0_n[31:16];
						f_rate = ff0_n[63:32];
						f_align = ff1_n[15:0];
						f_bits = ff1_n[31:16];
						f_valid = ff1_n[47:32];
						f_sub = ff1_n[63:48];
						ext = (f_tag == FMT_EXT) && (size_q >= 32'd40);
						if ((k_fmt == 33'd15 && !ext) || k_fmt == 33'd25) begin
							st_v = 1'b1;
							etag = f_tag;
							fbw = f_nch[7:0] * {3'd0, f_bits[7:3]};
							if (f_tag == FMT_EXT && size_q < 32'd40) st = ST_CORRUPT;
							else if (f_tag == FMT_EXT && f_valid != 16'd0 && f_valid != f_bits)
								st = ST_UNSUP;
							else begin
								if (f_tag == FMT_EXT) etag = f_sub;
								if (etag != FMT_PCM && etag != FMT_FLOAT) st = ST_UNSUP;
								else if (f_nch < 16'd1 || f_nch > 16'(MAX_CHANNELS)) st = ST_RANGE;
								else if (f_rate < {8'd0, min_rate} || f_rate > {8'd0, max_rate})
									st = ST_RANGE;
								else if ((etag == FMT_FLOAT) ? !(f_bits == 16'd32 || f_bits == 16'd64)
									: !(f_bits == 16'd8 || f_bits == 16'd16 || f_bits == 16'd24
									|| f_bits == 16'd32)) st = ST_UNSUP;
								else if (f_align != 16'd0 && f_align != {8'd0, fbw}) st = ST_CORRUPT;
								else begin
									st_v = 1'b0;
									commit = 1'b1;
									c_float = (etag == FMT_FLOAT);
									c_fb = fbw[6:0];
									adv_v = 1'b1;
									adv_nx = fstart + {1'b0, size_q} + {32'd0, size_q[0]};
								end
							end
						end
					end
				end
				default: ;
			endcase
			if (adv_v && ({1'b0, adv_nx} + 34'd8 > {2'b0, riff_end_q})) begin
				adv_v = 1'b0;
				st_v = 1'b1;
				st = ST_CORRUPT;
			end
			if (!st_v && last_byte) begin
				st_v = 1'b1;
				st = ST_CORRUPT;
			end
		end
		e_riff = 33'd8 + {1'b0, size_n};
		if (e_riff > {1'b0, buffer_length} || e_riff < 33'd12) e_riff = {1'b0, buffer_length};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			pos_q <= '0;
			riff_end_q <= '0;
			tag_q <= '0;
			size_q <= '0;
			next_q <= 32'd12;
			ff0_q <= '0;
			ff1_q <= '0;
			cf_float_q <= 1'b0;
			cf_nch_q <= '0;
			cf_rate_q <= '0;
			cf_bits_q <= '0;
			cf_fb_q <= '0;
			fmt_seen_q <= 1'b0;
			given_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid && st_v;
			if (st_v) begin
				out_item.status <= st;
				out_item.is_float <= (st == ST_OK) ? cf_float_q : 1'b0;
				out_item.channels <= (st == ST_OK) ? cf_nch_q : '0;
				out_item.sample_rate <= (st == ST_OK) ? cf_rate_q : '0;
				out_item.sample_bits <= (st == ST_OK) ? cf_bits_q : '0;
				out_item.frame_bytes <= (st == ST_OK) ? cf_fb_q : '0;
				out_item.data_offset <= dat_off;
				out_item.data_length <= dat_len;
			end
			if (in_valid) begin
				if (last_byte) begin
					phase_q <= PH_RIFF;
					pos_q <= '0;
					riff_end_q <= '0;
					tag_q <= '0;
					size_q <= '0;
					next_q <= 32'd12;
					ff0_q <= '0;
					ff1_q <= '0;
					cf_float_q <= 1'b0;
					cf_nch_q <= '0;
					cf_rate_q <= '0;
					cf_bits_q <= '0;
					cf_fb_q <= '0;
					fmt_seen_q <= 1'b0;
					given_q <= 1'b0;
				end else if (!given_q) begin
					pos_q <= pos_q + 32'd1;
					tag_q <= tag_n;
					size_q <= size_n;
					ff0_q <= ff0_n;
					ff1_q <= ff1_n;
					if (phase_q == PH_RIFF && pos_q == 32'd7) riff_end_q <= e_riff[31:0];
					if (st_v) given_q <= 1'b1;
					if (to_fmt) begin
						size_q <= size_fmt;
						ff0_q <= '0;
						ff1_q <= '0;
						phase_q <= PH_FMT;
					end
					if (adv_v) begin
						next_q <= adv_nx[31:0];
						phase_q <= PH_HDR;
					end
					if (commit) begin
						cf_float_q <= c_float;
						cf_nch_q <= f_nch[3:0];
						cf_rate_q <= f_rate[23:0];
						cf_bits_q <= f_bits[6:0];
						cf_fb_q <= c_fb;
						fmt_seen_q <= 1'b1;
					end
				end
			end
		end
	end

	`include "wav_header_stream_parser_top_assert.svh"
	`WHP_ASSERT_NEVER(a_adv_and_fmt, clk, arst_n, (adv_v && to_fmt))
	`WHP_ASSERT_IMPL(a_one_result, clk, arst_n, (out_valid && !$past(last_byte) |-> given_q))
	`WHP_ASSERT_NEVER(a_ok_needs_fmt, clk, arst_n, (in_valid && st_v && st == ST_OK && !fmt_seen_q))
endmodule

### rtl/whp_back.sv
module whp_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input whp_pkg::outcome_t in_item,
	output logic in_ready,
	output logic out_valid,
	output whp_pkg::result_t out_item,
	input logic out_ready
);
	import whp_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} state_t;

	state_t state_q;
	outcome_t item_q;
	logic [31:0] quo_q, rem_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_HOLD);
	assign trial = {rem_q, quo_q[31]} - {26'd0, item_q.frame_bytes};

	always_comb begin
		out_item.status = item_q.status;
		out_item.is_float = item_q.is_float;
		out_item.channels = item_q.channels;
		out_item.sample_rate = item_q.sample_rate;
		out_item.sample_bits = item_q.sample_bits;
		out_item.frame_bytes = item_q.frame_bytes;
		out_item.data_offset = item_q.data_offset;
		out_item.data_length = item_q.data_length;
		out_item.frame_count = (item_q.frame_bytes == 7'd0) ? 32'd0 : quo_q;
	end

	// Restoring divide, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					item_q <= in_item;
					quo_q <= in_item.data_length;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], quo_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_HOLD;
				end
				S_HOLD: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "wav_header_stream_parser_top_assert.svh"
	`WHP_ASSERT_NEVER(a_cnt_range, clk, arst_n, (state_q == S_DIV && cnt_q > 6'd31))
	`WHP_ASSERT_IMPL(a_hold_stable, clk, arst_n, (out_valid && !out_ready |=> out_valid))
	`WHP_ASSERT_IMPL(a_take, clk, arst_n, (in_valid && in_ready |=> state_q == S_DIV))
endmodule
